[rtl/core/gbn_pkg.sv]
// types and constants for the greedy box suppression block
// no dependencies
package gbn_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int LEVEL_W = 10;
    localparam int ANCHOR_W = 32;
    localparam int SRC_W = 6;
    localparam int THR_W = 16;
    localparam int THR_RESET = 32768;
    // one pixel in q12.4
    localparam int PIXEL_ONE = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_edge;
        logic signed [COORD_W-1:0] top_edge;
        logic signed [COORD_W-1:0] right_edge;
        logic signed [COORD_W-1:0] bottom_edge;
        logic [SCORE_W-1:0]        confidence;
        logic [LEVEL_W-1:0]        level_tag;
        logic [ANCHOR_W-1:0]       anchor_tag;
        logic                      batch_end;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_left;
        logic signed [COORD_W-1:0] kept_top;
        logic signed [COORD_W-1:0] kept_right;
        logic signed [COORD_W-1:0] kept_bottom;
        logic [SCORE_W-1:0]        kept_score;
        logic [LEVEL_W-1:0]        kept_level;
        logic [ANCHOR_W-1:0]       kept_anchor;
        logic [SRC_W-1:0]          source_position;
        logic                      run_end;
        logic                      capacity_exceeded;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_edge;
        logic signed [COORD_W-1:0] top_edge;
        logic signed [COORD_W-1:0] right_edge;
        logic signed [COORD_W-1:0] bottom_edge;
    } corner_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level_tag;
        logic [ANCHOR_W-1:0] anchor_tag;
    } tag_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RK_RD_I,
        ST_RK_CUR,
        ST_RK_RD_J,
        ST_RK_CMP,
        ST_RK_PUT,
        ST_SP_RD_I,
        ST_SP_CHK_I,
        ST_SP_AREA_A,
        ST_SP_MUL_A,
        ST_SP_EMIT,
        ST_SP_RD_K,
        ST_SP_CHK_K,
        ST_SP_GEOM,
        ST_SP_MUL,
        ST_SP_UNI,
        ST_SP_THR,
        ST_SP_DEC,
        ST_SP_NEXT_K,
        ST_SP_NEXT_I,
        ST_SP_FLUSH
    } back_state_t;

endpackage

[rtl/core/gbn_front.sv]
// load side: counts boxes, writes the box store, hands a finished batch to the back end
// depends on gbn_pkg
module gbn_front #(
    parameter int MAX_BOXES = 64,
    parameter int IW = $clog2(MAX_BOXES),
    parameter int CW = $clog2(MAX_BOXES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  gbn_pkg::in_word_t box,
    input  logic              back_busy,
    input  logic              job_take,
    output logic              job_valid,
    output logic [CW-1:0]     job_count,
    output logic              job_ovf,
    output logic              wr_en,
    output logic [IW-1:0]     wr_addr
);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          job_valid_reg, job_valid_next;
    logic [CW-1:0] job_count_reg, job_count_next;
    logic          job_ovf_reg, job_ovf_next;
    logic          accept;
    logic          room;

    assign full    = job_valid_reg || back_busy;
    assign accept  = push && !full;
    assign room    = count_reg < CW'(MAX_BOXES);
    assign wr_en   = accept && room;
    assign wr_addr = count_reg[IW-1:0];

    assign job_valid = job_valid_reg;
    assign job_count = job_count_reg;
    assign job_ovf   = job_ovf_reg;

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        job_valid_next = job_valid_reg && !job_take;
        job_count_next = job_count_reg;
        job_ovf_next   = job_ovf_reg;
        if (accept)
        begin
            if (room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (box.batch_end)
            begin
                job_valid_next = 1'b1;
                job_count_next = count_next;
                job_ovf_next   = ovf_next;
                count_next     = '0;
                ovf_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_count_reg <= job_count_next;
        job_ovf_reg   <= job_ovf_next;
    end

endmodule

[rtl/core/gbn_store.sv]
// box store: corners, score and tags, one write port and one registered read port
// depends on gbn_pkg
module gbn_store #(
    parameter int MAX_BOXES = 64,
    parameter int IW = $clog2(MAX_BOXES)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [IW-1:0]              wr_addr,
    input  gbn_pkg::in_word_t          wr_data,
    input  logic                       rd_en,
    input  logic [IW-1:0]              rd_addr,
    output gbn_pkg::corner_t           rd_corner,
    output logic [gbn_pkg::SCORE_W-1:0] rd_score,
    output gbn_pkg::tag_t              rd_tag
);

    gbn_pkg::corner_t            corner_mem [MAX_BOXES];
    logic [gbn_pkg::SCORE_W-1:0] score_mem  [MAX_BOXES];
    gbn_pkg::tag_t               tag_mem    [MAX_BOXES];

    gbn_pkg::corner_t            corner_rd_reg;
    logic [gbn_pkg::SCORE_W-1:0] score_rd_reg;
    gbn_pkg::tag_t               tag_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            corner_mem[wr_addr] <= '{left_edge:   wr_data.left_edge,
                                     top_edge:    wr_data.top_edge,
                                     right_edge:  wr_data.right_edge,
                                     bottom_edge: wr_data.bottom_edge};
            score_mem[wr_addr]  <= wr_data.confidence;
            tag_mem[wr_addr]    <= '{level_tag:  wr_data.level_tag,
                                     anchor_tag: wr_data.anchor_tag};
        end
        if (rd_en)
        begin
            corner_rd_reg <= corner_mem[rd_addr];
            score_rd_reg  <= score_mem[rd_addr];
            tag_rd_reg    <= tag_mem[rd_addr];
        end
    end

    assign rd_corner = corner_rd_reg;
    assign rd_score  = score_rd_reg;
    assign rd_tag    = tag_rd_reg;

endmodule

[rtl/core/gbn_outq.sv]
// two-entry result queue between the back end and the result port
// depends on gbn_pkg
module gbn_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  gbn_pkg::out_word_t wr_data,
    output logic               q_full,
    output logic               empty,
    input  logic               pop,
    output gbn_pkg::out_word_t kept
);

    gbn_pkg::out_word_t slot_reg [2];
    logic               wp_reg, rp_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_pop, do_wr;

    assign empty  = cnt_reg == 2'd0;
    assign q_full = cnt_reg == 2'd2;
    assign do_pop = pop && !empty;
    assign do_wr  = wr && !q_full;
    assign kept   = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/gbn_back.sv]
// back end: ranks the stored batch by score, runs greedy suppression, feeds survivors out
// depends on gbn_pkg, reads the box store, holds rank and suppression memories
module gbn_back #(
    parameter int MAX_BOXES = 64,
    parameter int IW = $clog2(MAX_BOXES),
    parameter int CW = $clog2(MAX_BOXES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gbn_pkg::THR_W-1:0]   cfg_data,
    input  logic                        job_valid,
    input  logic [CW-1:0]               job_count,
    input  logic                        job_ovf,
    output logic                        job_take,
    output logic                        busy,
    output logic                        box_rd_en,
    output logic [IW-1:0]               box_rd_addr,
    input  gbn_pkg::corner_t            box_corner,
    input  logic [gbn_pkg::SCORE_W-1:0] box_score,
    input  gbn_pkg::tag_t               box_tag,
    input  logic                        q_full,
    output logic                        q_wr,
    output gbn_pkg::out_word_t          q_data
);

    gbn_pkg::back_state_t state_reg, state_next;

    logic [IW-1:0] rank_mem [MAX_BOXES];
    logic          mask_mem [MAX_BOXES];
    logic [IW-1:0] rank_rd_reg;
    logic          mask_rd_reg;

    logic          rank_rd_en, mask_rd_en, rank_we, mask_we, mask_wdata;
    logic [IW-1:0] rank_rd_addr, mask_rd_addr, mask_waddr;

    logic [gbn_pkg::THR_W-1:0]   thr_reg;
    logic [CW-1:0]               n_reg, i_reg, j_reg, k_reg, cnt_reg;
    logic                        ovf_reg;
    logic [gbn_pkg::SCORE_W-1:0] cur_reg;
    logic [IW-1:0]               a_reg;
    gbn_pkg::corner_t            abox_reg;
    logic [gbn_pkg::SCORE_W-1:0] ascore_reg;
    gbn_pkg::tag_t               atag_reg;
    logic signed [17:0]          wa_reg, ha_reg, w_reg, h_reg, wb_reg, hb_reg;
    logic signed [35:0]          area_a_reg, area_b_reg, inter_reg;
    logic signed [37:0]          uni_reg;
    logic [53:0]                 prod_reg;
    logic                        ovl_reg;
    logic                        pend_valid_reg;
    gbn_pkg::out_word_t          pend_reg;

    logic               beats;
    logic               kill;
    logic [53:0]        lhs;
    logic signed [17:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [17:0] ix1, iy1, ix2, iy2;

    localparam logic signed [17:0] ONE = 18'(gbn_pkg::PIXEL_ONE);

    assign beats = (box_score > cur_reg) || ((box_score == cur_reg) && (j_reg < i_reg));

    assign ax1 = {{2{abox_reg.left_edge[15]}}, abox_reg.left_edge};
    assign ay1 = {{2{abox_reg.top_edge[15]}}, abox_reg.top_edge};
    assign ax2 = {{2{abox_reg.right_edge[15]}}, abox_reg.right_edge};
    assign ay2 = {{2{abox_reg.bottom_edge[15]}}, abox_reg.bottom_edge};
    assign bx1 = {{2{box_corner.left_edge[15]}}, box_corner.left_edge};
    assign by1 = {{2{box_corner.top_edge[15]}}, box_corner.top_edge};
    assign bx2 = {{2{box_corner.right_edge[15]}}, box_corner.right_edge};
    assign by2 = {{2{box_corner.bottom_edge[15]}}, box_corner.bottom_edge};
    assign ix1 = (ax1 > bx1) ? ax1 : bx1;
    assign iy1 = (ay1 > by1) ? ay1 : by1;
    assign ix2 = (ax2 < bx2) ? ax2 : bx2;
    assign iy2 = (ay2 < by2) ? ay2 : by2;

    // inter is positive whenever it counts, so its low 35 bits are the value
    assign lhs  = {3'b000, inter_reg[34:0], 16'd0};
    // zero union means infinite ratio, negative union never suppresses
    assign kill = ovl_reg && ((uni_reg == '0) || (!uni_reg[37] && (lhs > prod_reg)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = gbn_pkg::ST_RK_RD_I;
                end
            end
            gbn_pkg::ST_RK_RD_I:   state_next = gbn_pkg::ST_RK_CUR;
            gbn_pkg::ST_RK_CUR:    state_next = gbn_pkg::ST_RK_RD_J;
            gbn_pkg::ST_RK_RD_J:   state_next = gbn_pkg::ST_RK_CMP;
            gbn_pkg::ST_RK_CMP:
            begin
                state_next = (j_reg + CW'(1) == n_reg) ? gbn_pkg::ST_RK_PUT
                                                       : gbn_pkg::ST_RK_RD_J;
            end
            gbn_pkg::ST_RK_PUT:
            begin
                state_next = (i_reg + CW'(1) == n_reg) ? gbn_pkg::ST_SP_RD_I
                                                       : gbn_pkg::ST_RK_RD_I;
            end
            gbn_pkg::ST_SP_RD_I:   state_next = gbn_pkg::ST_SP_CHK_I;
            gbn_pkg::ST_SP_CHK_I:
            begin
                state_next = mask_rd_reg ? gbn_pkg::ST_SP_NEXT_I : gbn_pkg::ST_SP_AREA_A;
            end
            gbn_pkg::ST_SP_AREA_A: state_next = gbn_pkg::ST_SP_MUL_A;
            gbn_pkg::ST_SP_MUL_A:  state_next = gbn_pkg::ST_SP_EMIT;
            gbn_pkg::ST_SP_EMIT:
            begin
                if (!(pend_valid_reg && q_full))
                begin
                    state_next = (i_reg + CW'(1) == n_reg) ? gbn_pkg::ST_SP_NEXT_I
                                                           : gbn_pkg::ST_SP_RD_K;
                end
            end
            gbn_pkg::ST_SP_RD_K:   state_next = gbn_pkg::ST_SP_CHK_K;
            gbn_pkg::ST_SP_CHK_K:
            begin
                state_next = mask_rd_reg ? gbn_pkg::ST_SP_NEXT_K : gbn_pkg::ST_SP_GEOM;
            end
            gbn_pkg::ST_SP_GEOM:   state_next = gbn_pkg::ST_SP_MUL;
            gbn_pkg::ST_SP_MUL:    state_next = gbn_pkg::ST_SP_UNI;
            gbn_pkg::ST_SP_UNI:    state_next = gbn_pkg::ST_SP_THR;
            gbn_pkg::ST_SP_THR:    state_next = gbn_pkg::ST_SP_DEC;
            gbn_pkg::ST_SP_DEC:    state_next = gbn_pkg::ST_SP_NEXT_K;
            gbn_pkg::ST_SP_NEXT_K:
            begin
                state_next = (k_reg + CW'(1) == n_reg) ? gbn_pkg::ST_SP_NEXT_I
                                                       : gbn_pkg::ST_SP_RD_K;
            end
            gbn_pkg::ST_SP_NEXT_I:
            begin
                state_next = (i_reg + CW'(1) == n_reg) ? gbn_pkg::ST_SP_FLUSH
                                                       : gbn_pkg::ST_SP_RD_I;
            end
            gbn_pkg::ST_SP_FLUSH:
            begin
                if (!q_full)
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            default:               state_next = gbn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_take     = 1'b0;
        box_rd_en    = 1'b0;
        box_rd_addr  = i_reg[IW-1:0];
        rank_rd_en   = 1'b0;
        rank_rd_addr = i_reg[IW-1:0];
        mask_rd_en   = 1'b0;
        mask_rd_addr = i_reg[IW-1:0];
        rank_we      = 1'b0;
        mask_we      = 1'b0;
        mask_waddr   = i_reg[IW-1:0];
        mask_wdata   = 1'b0;
        q_wr         = 1'b0;
        q_data       = pend_reg;
        unique case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                job_take = job_valid;
            end
            gbn_pkg::ST_RK_RD_I:
            begin
                box_rd_en = 1'b1;
            end
            gbn_pkg::ST_RK_RD_J:
            begin
                box_rd_en   = 1'b1;
                box_rd_addr = j_reg[IW-1:0];
            end
            gbn_pkg::ST_RK_PUT:
            begin
                rank_we = 1'b1;
                mask_we = 1'b1;
            end
            gbn_pkg::ST_SP_RD_I:
            begin
                rank_rd_en = 1'b1;
                mask_rd_en = 1'b1;
            end
            gbn_pkg::ST_SP_CHK_I, gbn_pkg::ST_SP_CHK_K:
            begin
                box_rd_en   = 1'b1;
                box_rd_addr = rank_rd_reg;
            end
            gbn_pkg::ST_SP_EMIT:
            begin
                q_wr = pend_valid_reg && !q_full;
            end
            gbn_pkg::ST_SP_RD_K:
            begin
                rank_rd_en   = 1'b1;
                rank_rd_addr = k_reg[IW-1:0];
                mask_rd_en   = 1'b1;
                mask_rd_addr = k_reg[IW-1:0];
            end
            gbn_pkg::ST_SP_DEC:
            begin
                mask_we    = kill;
                mask_waddr = k_reg[IW-1:0];
                mask_wdata = 1'b1;
            end
            gbn_pkg::ST_SP_FLUSH:
            begin
                q_wr           = !q_full;
                q_data.run_end = 1'b1;
            end
            default:
            begin
                job_take = 1'b0;
            end
        endcase
    end

    assign busy = state_reg != gbn_pkg::ST_IDLE;

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[cnt_reg[IW-1:0]] <= i_reg[IW-1:0];
        end
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        if (rank_rd_en)
        begin
            rank_rd_reg <= rank_mem[rank_rd_addr];
        end
        if (mask_rd_en)
        begin
            mask_rd_reg <= mask_mem[mask_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbn_pkg::ST_IDLE;
            thr_reg        <= gbn_pkg::THR_W'(gbn_pkg::THR_RESET);
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (state_reg == gbn_pkg::ST_IDLE)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (state_reg == gbn_pkg::ST_SP_EMIT && !(pend_valid_reg && q_full))
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                n_reg   <= job_count;
                ovf_reg <= job_ovf;
                i_reg   <= '0;
            end
            gbn_pkg::ST_RK_CUR:
            begin
                cur_reg <= box_score;
                j_reg   <= '0;
                cnt_reg <= '0;
            end
            gbn_pkg::ST_RK_CMP:
            begin
                if (beats)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                j_reg <= j_reg + CW'(1);
            end
            gbn_pkg::ST_RK_PUT:
            begin
                i_reg <= (i_reg + CW'(1) == n_reg) ? '0 : i_reg + CW'(1);
            end
            gbn_pkg::ST_SP_CHK_I:
            begin
                a_reg <= rank_rd_reg;
            end
            gbn_pkg::ST_SP_AREA_A:
            begin
                abox_reg   <= box_corner;
                ascore_reg <= box_score;
                atag_reg   <= box_tag;
                wa_reg     <= bx2 - bx1 + ONE;
                ha_reg     <= by2 - by1 + ONE;
            end
            gbn_pkg::ST_SP_MUL_A:
            begin
                area_a_reg <= wa_reg * ha_reg;
            end
            gbn_pkg::ST_SP_EMIT:
            begin
                if (!(pend_valid_reg && q_full))
                begin
                    pend_reg <= '{kept_left:         abox_reg.left_edge,
                                  kept_top:          abox_reg.top_edge,
                                  kept_right:        abox_reg.right_edge,
                                  kept_bottom:       abox_reg.bottom_edge,
                                  kept_score:        ascore_reg,
                                  kept_level:        atag_reg.level_tag,
                                  kept_anchor:       atag_reg.anchor_tag,
                                  source_position:   gbn_pkg::SRC_W'(a_reg),
                                  run_end:           1'b0,
                                  capacity_exceeded: ovf_reg};
                    k_reg    <= i_reg + CW'(1);
                end
            end
            gbn_pkg::ST_SP_GEOM:
            begin
                w_reg   <= ix2 - ix1 + ONE;
                h_reg   <= iy2 - iy1 + ONE;
                wb_reg  <= bx2 - bx1 + ONE;
                hb_reg  <= by2 - by1 + ONE;
                ovl_reg <= ((ix2 - ix1 + ONE) > 18'sd0) && ((iy2 - iy1 + ONE) > 18'sd0);
            end
            gbn_pkg::ST_SP_MUL:
            begin
                inter_reg  <= w_reg * h_reg;
                area_b_reg <= wb_reg * hb_reg;
            end
            gbn_pkg::ST_SP_UNI:
            begin
                uni_reg <= {{2{area_a_reg[35]}}, area_a_reg}
                         + {{2{area_b_reg[35]}}, area_b_reg}
                         - {{2{inter_reg[35]}}, inter_reg};
            end
            gbn_pkg::ST_SP_THR:
            begin
                prod_reg <= 54'(thr_reg) * 54'(uni_reg[36:0]);
            end
            gbn_pkg::ST_SP_NEXT_K:
            begin
                k_reg <= k_reg + CW'(1);
            end
            gbn_pkg::ST_SP_NEXT_I:
            begin
                i_reg <= i_reg + CW'(1);
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

endmodule

[rtl/core/greedy_box_nms.sv]
// greedy box suppression, top level: load front end, box store, rank/suppress back end
// loading takes one box per cycle while full is low; after the box marked batch_end the
// back end ranks the batch and then runs greedy suppression, serially through the single
// shared store read port and a serial compare sequence; output stalls hold it up; full
// stays high until the last survivor is queued
// reset clears control, the load counter and the threshold (0.5); memories hold no reset value
module greedy_box_nms #(
    parameter int MAX_BOXES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  gbn_pkg::in_word_t          box,
    output logic                       empty,
    input  logic                       pop,
    output gbn_pkg::out_word_t         kept,
    input  logic                       cfg_we,
    input  logic [gbn_pkg::THR_W-1:0]  cfg_data
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    logic                        back_busy, job_take, job_valid, job_ovf;
    logic [CW-1:0]               job_count;
    logic                        wr_en, rd_en;
    logic [IW-1:0]               wr_addr, rd_addr;
    gbn_pkg::corner_t            rd_corner;
    logic [gbn_pkg::SCORE_W-1:0] rd_score;
    gbn_pkg::tag_t               rd_tag;
    logic                        q_full, q_wr;
    gbn_pkg::out_word_t          q_data;

    gbn_front #(.MAX_BOXES(MAX_BOXES), .IW(IW), .CW(CW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .box       (box),
        .back_busy (back_busy),
        .job_take  (job_take),
        .job_valid (job_valid),
        .job_count (job_count),
        .job_ovf   (job_ovf),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr)
    );

    gbn_store #(.MAX_BOXES(MAX_BOXES), .IW(IW)) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (box),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_corner (rd_corner),
        .rd_score  (rd_score),
        .rd_tag    (rd_tag)
    );

    gbn_back #(.MAX_BOXES(MAX_BOXES), .IW(IW), .CW(CW)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .job_valid   (job_valid),
        .job_count   (job_count),
        .job_ovf     (job_ovf),
        .job_take    (job_take),
        .busy        (back_busy),
        .box_rd_en   (rd_en),
        .box_rd_addr (rd_addr),
        .box_corner  (rd_corner),
        .box_score   (rd_score),
        .box_tag     (rd_tag),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_data      (q_data)
    );

    gbn_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_data),
        .q_full  (q_full),
        .empty   (empty),
        .pop     (pop),
        .kept    (kept)
    );

endmodule

[test/greedy_box_nms_tb.sv]
// testbench for greedy_box_nms: random and directed box batches against a suppression predictor
// depends on gbn_pkg and the greedy_box_nms rtl
`timescale 1ns / 1ps

module greedy_box_nms_tb;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 200;

    class nms_scoreboard;
        gbn_pkg::in_word_t  box_store[CAPACITY];
        int                 box_count;
        bit                 box_overflow;
        logic [gbn_pkg::THR_W-1:0] iou_limit;
        gbn_pkg::out_word_t kept_queue[$];
        int                 error_count;

        function new();
            box_count = 0;
            box_overflow = 0;
            iou_limit = gbn_pkg::THR_W'(gbn_pkg::THR_RESET);
            error_count = 0;
        endfunction

        function void set_limit(logic [gbn_pkg::THR_W-1:0] v);
            iou_limit = v;
        endfunction

        function int waiting();
            return kept_queue.size();
        endfunction

        function longint area(gbn_pkg::in_word_t w);
            return (longint'(w.right_edge) - longint'(w.left_edge) + gbn_pkg::PIXEL_ONE) *
                   (longint'(w.bottom_edge) - longint'(w.top_edge) + gbn_pkg::PIXEL_ONE);
        endfunction

        function bit too_close(gbn_pkg::in_word_t a, gbn_pkg::in_word_t b);
            longint x1, y1, x2, y2, w, h, ovl, uni;
            x1 = a.left_edge > b.left_edge ? a.left_edge : b.left_edge;
            y1 = a.top_edge > b.top_edge ? a.top_edge : b.top_edge;
            x2 = a.right_edge < b.right_edge ? a.right_edge : b.right_edge;
            y2 = a.bottom_edge < b.bottom_edge ? a.bottom_edge : b.bottom_edge;
            w = x2 - x1 + gbn_pkg::PIXEL_ONE;
            h = y2 - y1 + gbn_pkg::PIXEL_ONE;
            if (w <= 0 || h <= 0)
                return 0;
            ovl = w * h;
            uni = area(a) + area(b) - ovl;
            if (uni == 0)
                return 1;
            if (uni < 0)
                return 0;
            return ovl * 65536 > longint'(iou_limit) * uni;
        endfunction

        // store the box; on batch end rank, suppress and queue the survivors
        function void note_box(gbn_pkg::in_word_t w);
            int rank[CAPACITY];
            bit dead[CAPACITY];
            int j, cur;
            gbn_pkg::in_word_t s;
            gbn_pkg::out_word_t o;
            bit any;
            if (box_count < CAPACITY)
            begin
                box_store[box_count] = w;
                box_count++;
            end
            else
            begin
                box_overflow = 1;
            end
            if (!w.batch_end)
                return;
            for (int i = 0; i < box_count; i++)
            begin
                cur = i;
                j = i;
                while (j > 0 &&
                       box_store[rank[j-1]].confidence < box_store[cur].confidence)
                begin
                    rank[j] = rank[j-1];
                    j--;
                end
                rank[j] = cur;
                dead[i] = 0;
            end
            any = 0;
            for (int i = 0; i < box_count; i++)
            begin
                if (!dead[i])
                begin
                    for (int k = i + 1; k < box_count; k++)
                        if (!dead[k] && too_close(box_store[rank[i]], box_store[rank[k]]))
                            dead[k] = 1;
                    s = box_store[rank[i]];
                    o.kept_left = s.left_edge;
                    o.kept_top = s.top_edge;
                    o.kept_right = s.right_edge;
                    o.kept_bottom = s.bottom_edge;
                    o.kept_score = s.confidence;
                    o.kept_level = s.level_tag;
                    o.kept_anchor = s.anchor_tag;
                    o.source_position = gbn_pkg::SRC_W'(rank[i]);
                    o.run_end = 0;
                    o.capacity_exceeded = box_overflow;
                    kept_queue.insert(kept_queue.size(), o);
                    any = 1;
                end
            end
            if (any)
                kept_queue[kept_queue.size()-1].run_end = 1;
            box_count = 0;
            box_overflow = 0;
        endfunction

        task report(string field, longint got, longint want);
            $display("mismatch %s: got %0h want %0h", field, got, want);
            error_count++;
        endtask

        task check_kept(gbn_pkg::out_word_t got);
            gbn_pkg::out_word_t want;
            if (kept_queue.size() == 0)
            begin
                report("unexpected word", got, 0);
                return;
            end
            want = kept_queue.pop_front();
            if (got.kept_left !== want.kept_left)
                report("kept_left", got.kept_left, want.kept_left);
            if (got.kept_top !== want.kept_top)
                report("kept_top", got.kept_top, want.kept_top);
            if (got.kept_right !== want.kept_right)
                report("kept_right", got.kept_right, want.kept_right);
            if (got.kept_bottom !== want.kept_bottom)
                report("kept_bottom", got.kept_bottom, want.kept_bottom);
            if (got.kept_score !== want.kept_score)
                report("kept_score", got.kept_score, want.kept_score);
            if (got.kept_level !== want.kept_level)
                report("kept_level", got.kept_level, want.kept_level);
            if (got.kept_anchor !== want.kept_anchor)
                report("kept_anchor", got.kept_anchor, want.kept_anchor);
            if (got.source_position !== want.source_position)
                report("source_position", got.source_position, want.source_position);
            if (got.run_end !== want.run_end)
                report("run_end", got.run_end, want.run_end);
            if (got.capacity_exceeded !== want.capacity_exceeded)
                report("capacity_exceeded", got.capacity_exceeded, want.capacity_exceeded);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic full;
    gbn_pkg::in_word_t box = '0;
    logic empty;
    logic pop = 0;
    gbn_pkg::out_word_t kept;
    logic cfg_we = 0;
    logic [gbn_pkg::THR_W-1:0] cfg_data = '0;

    nms_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 0;
    logic holding = 0;
    int cycles = 0;
    int sent = 0;

    greedy_box_nms #(.MAX_BOXES(CAPACITY)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .box(box),
        .empty(empty), .pop(pop), .kept(kept), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_kept(kept);
        pop <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // long output hold-off, counted here
    initial forever
    begin
        @(posedge clk);
        if (hold_go)
        begin
            holding <= 1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 0;
            hold_go = 0;
        end
    end

    task send_box(gbn_pkg::in_word_t w);
        int idle;
        box <= w;
        push <= 1;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_box(w);
        sent++;
        idle = ($urandom_range(99) < send_idle_pct) ? int'($urandom_range(3, 1)) : 0;
        if (idle > 0)
        begin
            push <= 0;
            repeat (idle) @(posedge clk);
        end
    endtask

    function gbn_pkg::in_word_t make_box(int cx, int cy, int span, bit last);
        gbn_pkg::in_word_t w;
        w.left_edge = 16'(cx - $urandom_range(span));
        w.top_edge = 16'(cy - $urandom_range(span));
        w.right_edge = 16'(cx + $urandom_range(span));
        w.bottom_edge = 16'(cy + $urandom_range(span));
        w.confidence = ($urandom_range(3) == 0) ? 16'($urandom_range(4) * 1000)
                                                : 16'($urandom);
        w.level_tag = gbn_pkg::LEVEL_W'($urandom);
        w.anchor_tag = $urandom;
        w.batch_end = last;
        if ($urandom_range(9) == 0)
            w = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), gbn_pkg::LEVEL_W'($urandom), 32'($urandom), last};
        return w;
    endfunction

    task send_batch(int n, int span);
        int cx, cy;
        cx = $urandom_range(2000) - 1000;
        cy = $urandom_range(2000) - 1000;
        for (int i = 0; i < n; i++)
            send_box(make_box(cx + $urandom_range(64), cy + $urandom_range(64), span,
                              i == n - 1));
    endtask

    task drain();
        push <= 0;
        @(posedge clk);
        while (sb.waiting() > 0 || full) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_limit(logic [gbn_pkg::THR_W-1:0] v);
        drain();
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_limit(v);
    endtask

    initial
    begin
        gbn_pkg::in_word_t w;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single boxes at the field extremes
        send_box({16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 10'h3ff, 32'hffffffff,
                  1'b1});
        send_box({16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 10'h000, 32'h0, 1'b1});
        // identical boxes with tied scores: arrival order decides the keeper
        w = {16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'd500, 10'd1, 32'd11, 1'b0};
        send_box(w);
        w.anchor_tag = 22;
        send_box(w);
        w.batch_end = 1;
        w.anchor_tag = 33;
        send_box(w);
        // disjoint boxes and a zero-area-width box
        send_box({16'sd0, 16'sd0, 16'sd32, 16'sd32, 16'd10, 10'd2, 32'd1, 1'b0});
        send_box({16'sd100, 16'sd100, 16'sd132, 16'sd132, 16'd900, 10'd3, 32'd2, 1'b0});
        send_box({16'sd10, 16'sd10, -16'sd6, 16'sd40, 16'd50, 10'd4, 32'd3, 1'b1});
        write_limit(16'hffff);
        w = {16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'd700, 10'd5, 32'd44, 1'b0};
        send_box(w);
        w.batch_end = 1;
        send_box(w);
        write_limit(16'h0000);
        send_batch(4, 200);
        // overflow: more boxes than the store holds, last one dropped too
        for (int i = 0; i < CAPACITY + 2; i++)
            send_box(make_box(i * 400, 0, 40, i == CAPACITY + 1));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 23;
                    recv_stall_pct = 23;
                end
            endcase
            write_limit(phase == 0 ? gbn_pkg::THR_W'(gbn_pkg::THR_RESET)
                                   : gbn_pkg::THR_W'($urandom));
            if (phase == 1)
            begin
                // output held off while disjoint survivors pile up and stall the input
                hold_go = 1;
                for (int i = 0; i < 6; i++)
                    send_box(make_box(i * 500, 0, 30, i == 5));
                send_batch(2, 100);
            end
            for (int b = 0; b < 3; b++)
            begin
                send_batch($urandom_range(1, 4), $urandom_range(10, 300));
                if (b == 1)
                begin
                    push <= 0;
                    @(posedge clk);
                    while (sb.waiting() > 0) @(posedge clk);
                end
            end
        end
        drain();
        if (sb.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
rtl/core/gbn_pkg.sv
rtl/core/gbn_front.sv
rtl/core/gbn_store.sv
rtl/core/gbn_outq.sv
rtl/core/gbn_back.sv
rtl/core/greedy_box_nms.sv
test/greedy_box_nms_tb.sv
